FILE: hw/rtl/tr2t_pkg.sv
// ----------------------------------------------------------------------------
// tr2t_pkg
// Types and constants shared by the raw-to-temperature converter and its cells.
// ----------------------------------------------------------------------------
package tr2t_pkg;

   localparam int RAW_W       = 16;
   localparam int TEMP_W      = 19;
   localparam int OBJ_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 40;

   localparam int GAIN_W      = 32;
   localparam int RATIO_W     = 40;
   localparam int PB_W        = 24;
   localparam int PF_W        = 24;

   localparam int LOG_FRAC    = 24;
   localparam int EXP_W       = 6;
   localparam int L2_W        = EXP_W + LOG_FRAC;
   localparam int LN_W        = 30;
   localparam int MANT_W      = 32;
   localparam int NORM_W      = 64;
   localparam int NORM_STAGES = 6;

   localparam int DIV1_NW     = RATIO_W + 16;
   localparam int DIV1_DW     = 32;
   localparam int DIV2_NW     = 48;

   localparam int TEMP_MAX       = 200000;
   localparam int KELVIN_CENTI   = 27315;
   localparam int K_W            = 18;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [7:0] BYTE_MASK = 8'h0ff;

   localparam logic [GAIN_W-1:0]  RST_GAIN   = 32'd65536;
   localparam logic [31:0]        RST_OFFSET = 32'd0;
   localparam logic [RATIO_W-1:0] RST_RATIO  = 40'd430716672;
   localparam logic [PB_W-1:0]    RST_B      = 24'd384256;
   localparam logic [PF_W-1:0]    RST_F      = 24'd65536;
   localparam logic [31:0]        RST_O      = 32'hFFE3_5400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWAP   = 3'd0,
      CSR_GAIN   = 3'd1,
      CSR_OFFSET = 3'd2,
      CSR_RATIO  = 3'd3,
      CSR_B      = 3'd4,
      CSR_F      = 3'd5,
      CSR_O      = 3'd6
   } csr_index_type;

endpackage

FILE: hw/rtl/tr2t_div_cell.sv
// ----------------------------------------------------------------------------
// tr2t_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module tr2t_div_cell #(
   parameter int NW = 56,
   parameter int DW = 32,
   parameter int SW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_v,
   input  logic [DW-1:0] in_rem,
   input  logic [NW-1:0] in_q,
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_v,
   output logic [DW-1:0] out_rem,
   output logic [NW-1:0] out_q,
   output logic [DW-1:0] out_div,
   output logic [SW-1:0] out_side
);

   logic          v_ff;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] div_ff;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial  = {in_rem, in_q[NW-1]};
      diff   = trial - {1'b0, in_div};
      ge     = (trial >= {1'b0, in_div});
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_in   = {in_q[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_v    = v_ff;
   assign out_rem  = rem_ff;
   assign out_q    = q_ff;
   assign out_div  = div_ff;
   assign out_side = side_ff;

endmodule

FILE: hw/rtl/tr2t_norm_cell.sv
// ----------------------------------------------------------------------------
// tr2t_norm_cell
// One normalizing shift step: moves the word left by a fixed amount when the
// top bits are zero and counts the shift.
// ----------------------------------------------------------------------------
module tr2t_norm_cell #(
   parameter int SH = 32,
   parameter int SW = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_v,
   input  logic [tr2t_pkg::NORM_W-1:0]  in_x,
   input  logic [tr2t_pkg::EXP_W-1:0]   in_lz,
   input  logic [SW-1:0]                in_side,
   output logic                         out_v,
   output logic [tr2t_pkg::NORM_W-1:0]  out_x,
   output logic [tr2t_pkg::EXP_W-1:0]   out_lz,
   output logic [SW-1:0]                out_side
);
   import tr2t_pkg::*;

   logic              v_ff;
   logic [NORM_W-1:0] x_ff, x_in;
   logic [EXP_W-1:0]  lz_ff, lz_in;
   logic [SW-1:0]     side_ff;
   logic              top_zero;

   always_comb begin
      top_zero = (in_x[NORM_W-1 -: SH] == '0);
      x_in     = top_zero ? (in_x << SH) : in_x;
      lz_in    = top_zero ? (in_lz + EXP_W'(SH)) : in_lz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         lz_ff   <= lz_in;
         side_ff <= in_side;
      end
   end

   assign out_v    = v_ff;
   assign out_x    = x_ff;
   assign out_lz   = lz_ff;
   assign out_side = side_ff;

endmodule

FILE: hw/rtl/tr2t_sqr_cell.sv
// ----------------------------------------------------------------------------
// tr2t_sqr_cell
// One log2 fraction step: squares the Q1.31 mantissa and yields one bit.
// ----------------------------------------------------------------------------
module tr2t_sqr_cell #(
   parameter int SW = 39
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_v,
   input  logic [tr2t_pkg::MANT_W-1:0]   in_m,
   input  logic [tr2t_pkg::LOG_FRAC-1:0] in_frac,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_v,
   output logic [tr2t_pkg::MANT_W-1:0]   out_m,
   output logic [tr2t_pkg::LOG_FRAC-1:0] out_frac,
   output logic [SW-1:0]                 out_side
);
   import tr2t_pkg::*;

   logic                  v_ff;
   logic [MANT_W-1:0]     m_ff, m_in;
   logic [LOG_FRAC-1:0]   frac_ff, frac_in;
   logic [SW-1:0]         side_ff;
   logic [2*MANT_W-1:0]   sq;
   logic [MANT_W:0]       t;

   always_comb begin
      sq      = (2*MANT_W)'(in_m) * (2*MANT_W)'(in_m);
      t       = sq[2*MANT_W-1:MANT_W-1];
      m_in    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      frac_in = {in_frac[LOG_FRAC-2:0], t[MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in;
         frac_ff <= frac_in;
         side_ff <= in_side;
      end
   end

   assign out_v    = v_ff;
   assign out_m    = m_ff;
   assign out_frac = frac_ff;
   assign out_side = side_ff;

endmodule

FILE: hw/rtl/thermal_raw_to_temperature.sv
// ----------------------------------------------------------------------------
// thermal_raw_to_temperature
// Converts raw thermal pixels to Celsius temperature by Planck inversion.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while req_stall is low and returns one
// result per pixel, in order. Most of the pipeline is made up of the two
// restoring divider chains (56 and 48 cells), the six-step normalizer and the
// 24 squaring cells of the log2 unit. A result that waits on rsp_stall goes
// into a one-entry skid register, and requests are stalled only while that
// register is full.
module thermal_raw_to_temperature #(
   parameter int RAW_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tr2t_pkg::RAW_W-1:0]           req_raw_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tr2t_pkg::TEMP_W-1:0]   rsp_temp_centi,
   output logic signed [tr2t_pkg::OBJ_W-1:0]    rsp_raw_object,
   output logic                                 rsp_valid_res,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tr2t_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tr2t_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tr2t_pkg::*;

   localparam int SIDE_W  = OBJ_W + 1;
   localparam int SQR_SW  = OBJ_W + 1 + EXP_W;
   localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((1 << RAW_BITS) - 1);

   logic                swap_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [31:0]         offset_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [PB_W-1:0]     b_ff;
   logic [PF_W-1:0]     f_ff;
   logic [31:0]         o_ff;

   logic en;
   logic accept;

   logic                 s1_v_ff;
   logic [47:0]          s1_prod_ff, s1_prod_in;
   logic [RAW_W-1:0]     raw_sel;
   logic                 s2_v_ff;
   logic [OBJ_W-1:0]     s2_obj_ff, s2_obj_in;
   logic [40:0]          scaled;
   logic signed [41:0]   obj_w;
   logic                 s3_v_ff;
   logic [OBJ_W-1:0]     s3_obj_ff;
   logic [DIV1_DW-1:0]   s3_d_ff;
   logic                 s3_ok_ff, s3_ok_in;
   logic [32:0]          d_w;

   logic                 d1_v    [0:DIV1_NW];
   logic [DIV1_DW-1:0]   d1_rem  [0:DIV1_NW];
   logic [DIV1_NW-1:0]   d1_q    [0:DIV1_NW];
   logic [DIV1_DW-1:0]   d1_div  [0:DIV1_NW];
   logic [SIDE_W-1:0]    d1_side [0:DIV1_NW];

   logic                 sa_v_ff;
   logic [NORM_W-1:0]    sa_x_ff;
   logic [OBJ_W-1:0]     sa_obj_ff;
   logic                 sa_ok_ff, sa_ok_in;
   logic [DIV1_NW:0]     arg_w;

   logic                 n_v    [0:NORM_STAGES];
   logic [NORM_W-1:0]    n_x    [0:NORM_STAGES];
   logic [EXP_W-1:0]     n_lz   [0:NORM_STAGES];
   logic [SIDE_W-1:0]    n_side [0:NORM_STAGES];

   logic                 q_v    [0:LOG_FRAC];
   logic [MANT_W-1:0]    q_m    [0:LOG_FRAC];
   logic [LOG_FRAC-1:0]  q_frac [0:LOG_FRAC];
   logic [SQR_SW-1:0]    q_side [0:LOG_FRAC];

   logic                 m1_v_ff;
   logic [61:0]          m1_prod_ff;
   logic [OBJ_W-1:0]     m1_obj_ff;
   logic                 m1_ok_ff;
   logic [L2_W-1:0]      l2;
   logic                 m2_v_ff;
   logic [LN_W-1:0]      m2_ln_ff, m2_ln_in;
   logic [OBJ_W-1:0]     m2_obj_ff;
   logic                 m2_ok_ff;
   logic                 m3_v_ff;
   logic [DIV2_NW-1:0]   m3_num_ff;
   logic [LN_W-1:0]      m3_ln_ff;
   logic [OBJ_W-1:0]     m3_obj_ff;
   logic                 m3_ok_ff;
   logic [DIV2_NW-1:0]   num_b;

   logic                 d2_v    [0:DIV2_NW];
   logic [LN_W-1:0]      d2_rem  [0:DIV2_NW];
   logic [DIV2_NW-1:0]   d2_q    [0:DIV2_NW];
   logic [LN_W-1:0]      d2_div  [0:DIV2_NW];
   logic [SIDE_W-1:0]    d2_side [0:DIV2_NW];

   logic                 fin_v_ff;
   logic [TEMP_W-1:0]    fin_temp_ff, fin_temp_in;
   logic [OBJ_W-1:0]     fin_obj_ff;
   logic                 fin_ok_ff;
   logic [K_W-1:0]       ksat;

   logic                 out_v_ff, out_v_in;
   logic [TEMP_W-1:0]    out_temp_ff;
   logic [OBJ_W-1:0]     out_obj_ff;
   logic                 out_ok_ff;
   logic                 skid_v_ff, skid_v_in;
   logic [TEMP_W-1:0]    skid_temp_ff;
   logic [OBJ_W-1:0]     skid_obj_ff;
   logic                 skid_ok_ff;
   logic                 take;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff   <= 1'b0;
         gain_ff   <= RST_GAIN;
         offset_ff <= RST_OFFSET;
         ratio_ff  <= RST_RATIO;
         b_ff      <= RST_B;
         f_ff      <= RST_F;
         o_ff      <= RST_O;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SWAP:   swap_ff   <= csr_wdata[0];
            CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_OFFSET: offset_ff <= csr_wdata[31:0];
            CSR_RATIO:  ratio_ff  <= csr_wdata[RATIO_W-1:0];
            CSR_B:      b_ff      <= csr_wdata[PB_W-1:0];
            CSR_F:      f_ff      <= csr_wdata[PF_W-1:0];
            CSR_O:      o_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_v_ff && !rsp_stall;

   always_comb begin
      raw_sel = req_raw_pixel & RAW_MASK;
      if (swap_ff) begin
         raw_sel = {raw_sel[7:0] & BYTE_MASK, raw_sel[15:8] & BYTE_MASK};
      end
      s1_prod_in = 48'(raw_sel) * 48'(gain_ff);
   end

   always_comb begin
      scaled = 41'((49'(s1_prod_ff) + 49'd128) >> 8);
      obj_w  = $signed({1'b0, scaled}) - $signed({{10{offset_ff[31]}}, offset_ff});
      if (obj_w > 42'sd2147483647) begin
         s2_obj_in = 32'h7FFF_FFFF;
      end else if (obj_w < -42'sd2147483648) begin
         s2_obj_in = 32'h8000_0000;
      end else begin
         s2_obj_in = obj_w[31:0];
      end
   end

   always_comb begin
      d_w      = {s2_obj_ff[31], s2_obj_ff} + {o_ff[31], o_ff};
      s3_ok_in = !d_w[32] && (d_w[31:0] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s2_obj_ff  <= s2_obj_in;
         s3_obj_ff  <= s2_obj_ff;
         s3_d_ff    <= d_w[31:0];
         s3_ok_ff   <= s3_ok_in;
      end
   end

   assign d1_v[0]    = s3_v_ff;
   assign d1_rem[0]  = '0;
   assign d1_q[0]    = {ratio_ff, 16'd0};
   assign d1_div[0]  = s3_d_ff;
   assign d1_side[0] = {s3_obj_ff, s3_ok_ff};

   for (genvar i = 0; i < DIV1_NW; i++) begin : g_div1
      tr2t_div_cell #(.NW(DIV1_NW), .DW(DIV1_DW), .SW(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_v     (d1_v[i]),
         .in_rem   (d1_rem[i]),
         .in_q     (d1_q[i]),
         .in_div   (d1_div[i]),
         .in_side  (d1_side[i]),
         .out_v    (d1_v[i+1]),
         .out_rem  (d1_rem[i+1]),
         .out_q    (d1_q[i+1]),
         .out_div  (d1_div[i+1]),
         .out_side (d1_side[i+1])
      );
   end

   always_comb begin
      arg_w    = (DIV1_NW+1)'(d1_q[DIV1_NW]) + (DIV1_NW+1)'(f_ff);
      sa_ok_in = d1_side[DIV1_NW][0] && (arg_w > (DIV1_NW+1)'(65536));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else if (en) begin
         sa_v_ff <= d1_v[DIV1_NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_x_ff   <= NORM_W'(arg_w);
         sa_obj_ff <= d1_side[DIV1_NW][SIDE_W-1:1];
         sa_ok_ff  <= sa_ok_in;
      end
   end

   assign n_v[0]    = sa_v_ff;
   assign n_x[0]    = sa_x_ff;
   assign n_lz[0]   = '0;
   assign n_side[0] = {sa_obj_ff, sa_ok_ff};

   for (genvar i = 0; i < NORM_STAGES; i++) begin : g_norm
      tr2t_norm_cell #(.SH(32 >> i), .SW(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_v     (n_v[i]),
         .in_x     (n_x[i]),
         .in_lz    (n_lz[i]),
         .in_side  (n_side[i]),
         .out_v    (n_v[i+1]),
         .out_x    (n_x[i+1]),
         .out_lz   (n_lz[i+1]),
         .out_side (n_side[i+1])
      );
   end

   assign q_v[0]    = n_v[NORM_STAGES];
   assign q_m[0]    = n_x[NORM_STAGES][NORM_W-1 -: MANT_W];
   assign q_frac[0] = '0;
   assign q_side[0] = {n_side[NORM_STAGES], EXP_W'(6'd47 - n_lz[NORM_STAGES])};

   for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sqr
      tr2t_sqr_cell #(.SW(SQR_SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_v     (q_v[i]),
         .in_m     (q_m[i]),
         .in_frac  (q_frac[i]),
         .in_side  (q_side[i]),
         .out_v    (q_v[i+1]),
         .out_m    (q_m[i+1]),
         .out_frac (q_frac[i+1]),
         .out_side (q_side[i+1])
      );
   end

   always_comb begin
      l2       = {q_side[LOG_FRAC][EXP_W-1:0], q_frac[LOG_FRAC]};
      m2_ln_in = LN_W'((63'(m1_prod_ff) + 63'(64'd2147483648)) >> 32);
      num_b    = (DIV2_NW'(b_ff) * DIV2_NW'(100)) << 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= q_v[LOG_FRAC];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_prod_ff <= 62'(l2) * 62'(LN2_Q32);
         m1_obj_ff  <= q_side[LOG_FRAC][SQR_SW-1 -: OBJ_W];
         m1_ok_ff   <= q_side[LOG_FRAC][EXP_W];
         m2_ln_ff   <= m2_ln_in;
         m2_obj_ff  <= m1_obj_ff;
         m2_ok_ff   <= m1_ok_ff && (m2_ln_in != '0);
         m3_num_ff  <= num_b + DIV2_NW'(m2_ln_ff >> 1);
         m3_ln_ff   <= m2_ln_ff;
         m3_obj_ff  <= m2_obj_ff;
         m3_ok_ff   <= m2_ok_ff;
      end
   end

   assign d2_v[0]    = m3_v_ff;
   assign d2_rem[0]  = '0;
   assign d2_q[0]    = m3_num_ff;
   assign d2_div[0]  = m3_ln_ff;
   assign d2_side[0] = {m3_obj_ff, m3_ok_ff};

   for (genvar i = 0; i < DIV2_NW; i++) begin : g_div2
      tr2t_div_cell #(.NW(DIV2_NW), .DW(LN_W), .SW(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_v     (d2_v[i]),
         .in_rem   (d2_rem[i]),
         .in_q     (d2_q[i]),
         .in_div   (d2_div[i]),
         .in_side  (d2_side[i]),
         .out_v    (d2_v[i+1]),
         .out_rem  (d2_rem[i+1]),
         .out_q    (d2_q[i+1]),
         .out_div  (d2_div[i+1]),
         .out_side (d2_side[i+1])
      );
   end

   always_comb begin
      if (d2_q[DIV2_NW] > DIV2_NW'(TEMP_MAX + KELVIN_CENTI)) begin
         ksat = K_W'(TEMP_MAX + KELVIN_CENTI);
      end else begin
         ksat = d2_q[DIV2_NW][K_W-1:0];
      end
      if (d2_side[DIV2_NW][0]) begin
         fin_temp_in = TEMP_W'($signed({1'b0, ksat}) - TEMP_W'(KELVIN_CENTI));
      end else begin
         fin_temp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= d2_v[DIV2_NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_temp_ff <= fin_temp_in;
         fin_obj_ff  <= d2_side[DIV2_NW][SIDE_W-1:1];
         fin_ok_ff   <= d2_side[DIV2_NW][0];
      end
   end

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      if (en && fin_v_ff) begin
         out_v_in = 1'b1;
         if (out_v_ff && !take) begin
            skid_v_in = 1'b1;
         end
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_in = 1'b0;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && fin_v_ff) begin
         if (!out_v_ff || take) begin
            out_temp_ff <= fin_temp_ff;
            out_obj_ff  <= fin_obj_ff;
            out_ok_ff   <= fin_ok_ff;
         end else begin
            skid_temp_ff <= fin_temp_ff;
            skid_obj_ff  <= fin_obj_ff;
            skid_ok_ff   <= fin_ok_ff;
         end
      end else if (skid_v_ff && take) begin
         out_temp_ff <= skid_temp_ff;
         out_obj_ff  <= skid_obj_ff;
         out_ok_ff   <= skid_ok_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_temp_centi = $signed(out_temp_ff);
   assign rsp_raw_object = $signed(out_obj_ff);
   assign rsp_valid_res  = out_ok_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && take) |=> (out_v_ff && !skid_v_ff))
      else $error("skid entry did not move to the output register");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_temp_centi == '0))
      else $error("invalid result carries a nonzero temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temp_centi <= 19'sd200000 && rsp_temp_centi >= -19'sd27315))
      else $error("temperature outside the saturated range");

endmodule

FILE: dv/tb_thermal_raw_to_temperature.sv
// ----------------------------------------------------------------------------
// tb_thermal_raw_to_temperature
// Self-checking test of the raw-to-temperature converter. Pixels go in under
// several register settings. A fixed-point model of the Planck inversion
// predicts each result, and results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_thermal_raw_to_temperature;
   timeunit 1ns;
   timeprecision 1ps;
   import tr2t_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int NUM_REGS = 7;
   localparam int SETTLE = 160;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic signed [TEMP_W-1:0] temp_centi;
      logic signed [OBJ_W-1:0]  raw_object;
      logic                     valid_res;
   } temp_result_type;

   class temp_scoreboard;
      logic [CSR_DATA_W-1:0] regs [NUM_REGS];
      temp_result_type       expected_q [$];
      int                    fails;

      function new();
         regs[CSR_SWAP]   = 0;
         regs[CSR_GAIN]   = RST_GAIN;
         regs[CSR_OFFSET] = RST_OFFSET;
         regs[CSR_RATIO]  = RST_RATIO;
         regs[CSR_B]      = RST_B;
         regs[CSR_F]      = RST_F;
         regs[CSR_O]      = RST_O;
         fails = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SWAP:   regs[idx] = data[0];
            CSR_GAIN:   regs[idx] = data[31:0];
            CSR_OFFSET: regs[idx] = data[31:0];
            CSR_RATIO:  regs[idx] = data;
            CSR_B:      regs[idx] = data[23:0];
            CSR_F:      regs[idx] = data[23:0];
            CSR_O:      regs[idx] = data[31:0];
            default: ;
         endcase
      endfunction

      function longint sext32(logic [CSR_DATA_W-1:0] v);
         logic signed [31:0] s;
         s = v[31:0];
         return longint'(s);
      endfunction

      function longint unsigned log2_q24(longint unsigned x);
         int p;
         longint unsigned m, frac;
         p = 0;
         frac = 0;
         for (int i = 0; i < 64; i++) if (x[i]) p = i;
         m = (p > 31) ? (x >> (p - 31)) : (x << (31 - p));
         for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               m = m >> 1;
               frac = frac | 1;
            end
         end
         return (longint'(p - 16) << LOG_FRAC) | frac;
      endfunction

      function void note_pixel(logic [RAW_W-1:0] pixel);
         longint unsigned raw, scaled, q, arg, l2, ln, num, k;
         longint obj, d;
         temp_result_type r;
         raw = pixel;
         if (regs[CSR_SWAP][0]) raw = {pixel[7:0], pixel[15:8]};
         scaled = (raw * longint'(regs[CSR_GAIN]) + 128) >> 8;
         obj = longint'(scaled) - sext32(regs[CSR_OFFSET]);
         if (obj > 64'sd2147483647) obj = 64'sd2147483647;
         if (obj < -64'sd2147483648) obj = -64'sd2147483648;
         r.temp_centi = 0;
         r.raw_object = obj[31:0];
         r.valid_res = 0;
         d = obj + sext32(regs[CSR_O]);
         if (d > 0) begin
            q = (longint'(regs[CSR_RATIO]) << 16) / longint'(d);
            arg = q + regs[CSR_F];
            if (arg > 65536) begin
               l2 = log2_q24(arg);
               ln = (l2 * 64'd2977044472 + 64'h8000_0000) >> 32;
               if (ln != 0) begin
                  num = (longint'(regs[CSR_B]) * 100) << 16;
                  k = (num + ln / 2) / ln;
                  if (k > TEMP_MAX + KELVIN_CENTI) k = TEMP_MAX + KELVIN_CENTI;
                  d = longint'(k) - KELVIN_CENTI;
                  r.temp_centi = d[TEMP_W-1:0];
                  r.valid_res = 1;
               end
            end
         end
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         fails++;
      endtask

      task check_result(temp_result_type got);
         temp_result_type exp_r;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no pending request");
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.temp_centi !== exp_r.temp_centi)
            report_mismatch($sformatf("temp_centi %0d, expected %0d",
                                      got.temp_centi, exp_r.temp_centi));
         if (got.raw_object !== exp_r.raw_object)
            report_mismatch($sformatf("raw_object %0d, expected %0d",
                                      got.raw_object, exp_r.raw_object));
         if (got.valid_res !== exp_r.valid_res)
            report_mismatch($sformatf("valid_res %0b, expected %0b",
                                      got.valid_res, exp_r.valid_res));
      endtask
   endclass

   logic                        clock = 0;
   logic                        reset = 1;
   logic                        req_valid = 0;
   logic                        req_stall;
   logic [RAW_W-1:0]            req_raw_pixel = 0;
   logic                        rsp_valid;
   logic                        rsp_stall = 0;
   logic signed [TEMP_W-1:0]    rsp_temp_centi;
   logic signed [OBJ_W-1:0]     rsp_raw_object;
   logic                        rsp_valid_res;
   logic                        csr_valid = 0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = 0;
   logic [CSR_DATA_W-1:0]       csr_wdata = 0;

   temp_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_seq = 0;
   int cycles = 0;

   thermal_raw_to_temperature dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      temp_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.temp_centi = rsp_temp_centi;
         got.raw_object = rsp_raw_object;
         got.valid_res  = rsp_valid_res;
         sb.check_result(got);
      end
   end

   int hold_left = 0;
   int hold_seen = 0;
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_pixel(logic [RAW_W-1:0] pixel);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(3, 1);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_raw_pixel <= pixel;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(pixel);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_all(logic [CSR_DATA_W-1:0] v [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) write_csr(i[CSR_IDX_W-1:0], v[i]);
   endtask

   function automatic logic [RAW_W-1:0] random_pixel();
      if ($urandom_range(1)) return RAW_W'($urandom());
      return RAW_W'($urandom_range(20000, 7000));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] v [NUM_REGS];
      logic [CSR_DATA_W-1:0] reset_vals [NUM_REGS];
      reset_vals = '{0, RST_GAIN, RST_OFFSET, RST_RATIO, RST_B, RST_F, RST_O};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_pixel(16'h0000);
      send_pixel(16'hffff);
      send_pixel(16'h00ff);
      send_pixel(16'hff00);
      send_pixel(16'h8000);
      send_pixel(16'd9000);
      send_pixel(16'd20000);
      drain();
      write_csr(CSR_UNUSED, '1);
      write_csr(CSR_SWAP, 1);
      send_pixel(16'h2a1c);
      send_pixel(16'h00ff);
      send_pixel(16'h4e20);
      drain();
      write_csr(CSR_B, 24'hffffff);
      send_pixel(16'd40000);
      send_pixel(16'hffff);
      drain();
      write_csr(CSR_RATIO, 0);
      write_csr(CSR_F, 24'd65537);
      send_pixel(16'd30000);
      drain();
      write_csr(CSR_F, 24'd65536);
      send_pixel(16'd30000);
      drain();
      v = '{0, 32'hffffffff, 32'h80000000, 40'hffffffffff, 24'd384256, 24'd65536, 32'd0};
      load_all(v);
      send_pixel(16'hffff);
      send_pixel(16'h0000);
      drain();
      write_csr(CSR_OFFSET, 32'h7fffffff);
      write_csr(CSR_GAIN, 0);
      send_pixel(16'h1234);
      send_pixel(16'hffff);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 7;  recv_idle_pct = 65; end
            1: begin send_idle_pct = 65; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph)
            0, 5: v = reset_vals;
            1: v = '{1, $urandom_range(90000, 50000), $urandom_range(4096) - 2048,
                     RST_RATIO, RST_B, RST_F, RST_O};
            2: v = '{1, 32'hffffffff, 32'hffffffff, 40'hffffffffff, 24'hffffff,
                     24'hffffff, 32'h7fffffff};
            3: v = '{0, 0, 0, 0, 0, 0, 0};
            default: v = '{$urandom(), $urandom(), $urandom(),
                           CSR_DATA_W'({$urandom(), $urandom()}), $urandom(), $urandom(),
                           $urandom()};
         endcase
         load_all(v);
         if (ph == 1) hold_seq++;
         for (int n = 0; n < 300; n++) send_pixel(random_pixel());
         drain();
      end

      if (sb.fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/tr2t_pkg.sv
hw/rtl/tr2t_div_cell.sv
hw/rtl/tr2t_norm_cell.sv
hw/rtl/tr2t_sqr_cell.sv
hw/rtl/thermal_raw_to_temperature.sv
dv/tb_thermal_raw_to_temperature.sv
